### src/rpfa_pkg.sv
// ============================================================================
// rpfa_pkg
// Shared constants, codes and types of the page-frame allocator.
// ============================================================================
package rpfa_pkg;

    localparam int NUM_FRAMES = 512;
    localparam int MAX_DUMP   = 64;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
    localparam int PAGE_W     = 20;
    localparam int RND_W      = 32;
    localparam int DUMP_W     = 7;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;
    localparam logic [STAT_W-1:0] ST_BIG_DUMP = 2'd3;

    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] addr;
        logic [FRAME_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_result;

endpackage

### src/rpfa_ram.sv
// ============================================================================
// rpfa_ram
// Single-port synchronous RAM, read-first, with a registered read.
// ============================================================================
module rpfa_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read at one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/rpfa_mod.sv
// ============================================================================
// rpfa_mod
// Restoring remainder unit: random draw modulo free count, one bit a cycle.
// ============================================================================
module rpfa_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rpfa_pkg::RND_W-1:0]   i_dividend,
    input  logic [rpfa_pkg::COUNT_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [rpfa_pkg::COUNT_W-1:0] o_rem
);
    import rpfa_pkg::*;

    localparam int CNT_W = $clog2(RND_W + 1);

    logic [RND_W-1:0]   r_q;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [COUNT_W:0]   trial;

    // shift in next dividend bit, subtract when it fits
    assign trial = {r_rem, r_q[RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[RND_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= COUNT_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[COUNT_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### src/rpfa_ctrl.sv
// ============================================================================
// rpfa_ctrl
// Request sequencer: read-modify-write over the free and recent list RAMs.
// ============================================================================
module rpfa_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [rpfa_pkg::REQ_W-1:0]   i_req_type,
    input  logic [rpfa_pkg::PAGE_W-1:0]  i_page_number,
    input  logic [rpfa_pkg::RND_W-1:0]   i_random_value,
    input  logic [rpfa_pkg::DUMP_W-1:0]  i_dump_count,
    input  logic [rpfa_pkg::PAGE_W-1:0]  i_base,
    input  logic                         i_out_free,
    output rpfa_pkg::t_result            o_result,
    output rpfa_pkg::t_mem_req           o_free_req,
    input  logic [rpfa_pkg::FRAME_W-1:0] i_free_rdata,
    output rpfa_pkg::t_mem_req           o_recent_req,
    input  logic [rpfa_pkg::FRAME_W-1:0] i_recent_rdata
);
    import rpfa_pkg::*;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DIV    = 5'd2;
    localparam logic [4:0] S_FRD    = 5'd3;
    localparam logic [4:0] S_FGET   = 5'd4;
    localparam logic [4:0] S_FSH_C  = 5'd5;
    localparam logic [4:0] S_FSH_R  = 5'd6;
    localparam logic [4:0] S_FSH_W  = 5'd7;
    localparam logic [4:0] S_RSH_C  = 5'd8;
    localparam logic [4:0] S_RSH_R  = 5'd9;
    localparam logic [4:0] S_RSH_W  = 5'd10;
    localparam logic [4:0] S_RPUT   = 5'd11;
    localparam logic [4:0] S_SR_C   = 5'd12;
    localparam logic [4:0] S_SR_R   = 5'd13;
    localparam logic [4:0] S_SR_M   = 5'd14;
    localparam logic [4:0] S_RDEL_C = 5'd15;
    localparam logic [4:0] S_RDEL_R = 5'd16;
    localparam logic [4:0] S_RDEL_W = 5'd17;
    localparam logic [4:0] S_FINS_C = 5'd18;
    localparam logic [4:0] S_FINS_R = 5'd19;
    localparam logic [4:0] S_FINS_W = 5'd20;
    localparam logic [4:0] S_FPUT   = 5'd21;
    localparam logic [4:0] S_DRD    = 5'd22;
    localparam logic [4:0] S_DOUT   = 5'd23;
    localparam logic [4:0] S_EMIT   = 5'd24;

    logic [4:0]         r_state, n_state;
    logic [4:0]         r_ret, n_ret;
    logic [COUNT_W-1:0] r_idx, n_idx;
    logic [COUNT_W-1:0] r_fcnt, n_fcnt;
    logic [COUNT_W-1:0] r_rcnt, n_rcnt;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [DUMP_W-1:0]  r_num, n_num;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic [STAT_W-1:0]  r_stat, n_stat;
    logic               r_last, n_last;

    logic               div_start;
    logic               div_done;
    logic [COUNT_W-1:0] div_rem;
    logic [PAGE_W-1:0]  free_off;
    logic [COUNT_W-1:0] idx_inc;
    logic [COUNT_W-1:0] idx_dec;

    rpfa_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_random_value),
        .i_divisor  (r_fcnt),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign free_off = i_page_number - i_base;
    assign idx_inc  = r_idx + 1'b1;
    assign idx_dec  = r_idx - 1'b1;

    // sequence one request through the lists
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_idx     = r_idx;
        n_fcnt    = r_fcnt;
        n_rcnt    = r_rcnt;
        n_frame   = r_frame;
        n_num     = r_num;
        n_page    = r_page;
        n_stat    = r_stat;
        n_last    = r_last;
        div_start = 1'b0;
        o_free_req   = '0;
        o_recent_req = '0;
        o_result     = '0;
        o_req_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_CLEAR: begin
                o_free_req.we    = 1'b1;
                o_free_req.addr  = r_idx[FRAME_W-1:0];
                o_free_req.wdata = FRAME_W'(NUM_FRAMES - 1) - r_idx[FRAME_W-1:0];
                n_idx = idx_inc;
                if (r_idx == COUNT_W'(NUM_FRAMES - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_ret  = S_IDLE;
                n_page = '0;
                n_last = 1'b1;
                if (i_req_valid) begin
                    priority case (i_req_type)
                        REQ_ALLOC: begin
                            if (r_fcnt == '0) begin
                                n_stat  = ST_OOM;
                                n_state = S_EMIT;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        REQ_FREE: begin
                            if (free_off >= PAGE_W'(NUM_FRAMES)) begin
                                n_stat  = ST_BAD_FREE;
                                n_state = S_EMIT;
                            end else begin
                                n_frame = free_off[FRAME_W-1:0];
                                n_idx   = '0;
                                n_state = S_SR_C;
                            end
                        end
                        REQ_DUMP: begin
                            if (COUNT_W'(i_dump_count) > r_rcnt
                                    || i_dump_count > DUMP_W'(MAX_DUMP)) begin
                                n_stat  = ST_BIG_DUMP;
                                n_state = S_EMIT;
                            end else if (i_dump_count != '0) begin
                                n_num   = i_dump_count;
                                n_idx   = '0;
                                n_state = S_DRD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // allocate: pick position, close the gap, push on recent list
            S_DIV: begin
                if (div_done) begin
                    n_idx   = div_rem;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                o_free_req.addr = r_idx[FRAME_W-1:0];
                n_state = S_FGET;
            end
            S_FGET: begin
                n_frame = i_free_rdata;
                n_state = S_FSH_C;
            end
            S_FSH_C: begin
                if (idx_inc < r_fcnt) begin
                    n_state = S_FSH_R;
                end else begin
                    n_idx   = r_rcnt;
                    n_state = S_RSH_C;
                end
            end
            S_FSH_R: begin
                o_free_req.addr = idx_inc[FRAME_W-1:0];
                n_state = S_FSH_W;
            end
            S_FSH_W: begin
                o_free_req.we    = 1'b1;
                o_free_req.addr  = r_idx[FRAME_W-1:0];
                o_free_req.wdata = i_free_rdata;
                n_idx   = idx_inc;
                n_state = S_FSH_C;
            end
            S_RSH_C: begin
                n_state = (r_idx != '0) ? S_RSH_R : S_RPUT;
            end
            S_RSH_R: begin
                o_recent_req.addr = idx_dec[FRAME_W-1:0];
                n_state = S_RSH_W;
            end
            S_RSH_W: begin
                o_recent_req.we    = 1'b1;
                o_recent_req.addr  = r_idx[FRAME_W-1:0];
                o_recent_req.wdata = i_recent_rdata;
                n_idx   = idx_dec;
                n_state = S_RSH_C;
            end
            S_RPUT: begin
                o_recent_req.we    = 1'b1;
                o_recent_req.wdata = r_frame;
                n_fcnt  = r_fcnt - 1'b1;
                n_rcnt  = r_rcnt + 1'b1;
                n_page  = i_base + PAGE_W'(r_frame);
                n_stat  = ST_OK;
                n_state = S_EMIT;
            end
            // free: find on recent list, close the gap, push on free list
            S_SR_C: begin
                if (r_idx < r_rcnt) begin
                    n_state = S_SR_R;
                end else begin
                    n_stat  = ST_BAD_FREE;
                    n_state = S_EMIT;
                end
            end
            S_SR_R: begin
                o_recent_req.addr = r_idx[FRAME_W-1:0];
                n_state = S_SR_M;
            end
            S_SR_M: begin
                if (i_recent_rdata == r_frame) begin
                    n_state = S_RDEL_C;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SR_C;
                end
            end
            S_RDEL_C: begin
                if (idx_inc < r_rcnt) begin
                    n_state = S_RDEL_R;
                end else begin
                    n_idx   = r_fcnt;
                    n_state = S_FINS_C;
                end
            end
            S_RDEL_R: begin
                o_recent_req.addr = idx_inc[FRAME_W-1:0];
                n_state = S_RDEL_W;
            end
            S_RDEL_W: begin
                o_recent_req.we    = 1'b1;
                o_recent_req.addr  = r_idx[FRAME_W-1:0];
                o_recent_req.wdata = i_recent_rdata;
                n_idx   = idx_inc;
                n_state = S_RDEL_C;
            end
            S_FINS_C: begin
                n_state = (r_idx != '0) ? S_FINS_R : S_FPUT;
            end
            S_FINS_R: begin
                o_free_req.addr = idx_dec[FRAME_W-1:0];
                n_state = S_FINS_W;
            end
            S_FINS_W: begin
                o_free_req.we    = 1'b1;
                o_free_req.addr  = r_idx[FRAME_W-1:0];
                o_free_req.wdata = i_free_rdata;
                n_idx   = idx_dec;
                n_state = S_FINS_C;
            end
            S_FPUT: begin
                o_free_req.we    = 1'b1;
                o_free_req.wdata = r_frame;
                n_fcnt  = r_fcnt + 1'b1;
                n_rcnt  = r_rcnt - 1'b1;
                n_stat  = ST_OK;
                n_state = S_EMIT;
            end
            // dump: read newest entries one word at a time
            S_DRD: begin
                o_recent_req.addr = r_idx[FRAME_W-1:0];
                n_state = S_DOUT;
            end
            S_DOUT: begin
                n_page  = i_base + PAGE_W'(i_recent_rdata);
                n_stat  = ST_OK;
                n_last  = (idx_inc == COUNT_W'(r_num));
                n_ret   = (idx_inc == COUNT_W'(r_num)) ? S_IDLE : S_DRD;
                n_idx   = idx_inc;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_result.valid  = i_out_free;
                o_result.page   = r_page;
                o_result.status = r_stat;
                o_result.last   = r_last;
                if (i_out_free) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_IDLE;
            r_idx   <= '0;
            r_fcnt  <= COUNT_W'(NUM_FRAMES);
            r_rcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_idx   <= n_idx;
            r_fcnt  <= n_fcnt;
            r_rcnt  <= n_rcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_num   <= n_num;
        r_page  <= n_page;
        r_stat  <= n_stat;
        r_last  <= n_last;
    end

    // free and recent counts together cover every frame of the region
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fcnt + r_rcnt) == COUNT_W'(NUM_FRAMES))
        else $error("free and recent counts do not cover the region");

    // remainder unit finishes only while an allocate waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("remainder done outside allocate");

    // a result is offered only in the emit state
    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (r_state == S_EMIT) && i_out_free)
        else $error("result pushed outside emit");

    // the position drawn lies inside the free list
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD) |-> (r_idx < r_fcnt))
        else $error("allocate position beyond free count");

endmodule

### src/random_page_frame_allocator.sv
// ============================================================================
// random_page_frame_allocator
// Page-frame allocator with a random-position free list and a recent list.
// ============================================================================
//  channel  | direction | contents
//  s_*      | in        | tuser: req_type; tdata: page_number, random_value,
//           |           |   dump_count
//  m_*      | out       | tdata: out_page; tuser: status; tlast: last_item
//  i_cfg_*  | in        | region_base_page, written when i_cfg_we is high
//
// One request at a time. Allocate waits on the remainder unit, reads the
// drawn frame, closes the gap in the free list and shifts the recent list
// to push it at the front. Free searches the recent list, closes its gap
// and shifts the free list; dump reads one word at a time. After reset the
// free list RAM is filled before s_tready rises. A stalled m_tready holds
// the sequencer in its emit state.
// ============================================================================
module random_page_frame_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // page_number[19:0], random_value[51:20],
                                   // dump_count[58:52], zero fill
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_page[19:0], zero fill
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata
);
    import rpfa_pkg::*;

    logic [PAGE_W-1:0]  r_base;
    logic               r_m_valid;
    logic [PAGE_W-1:0]  r_m_page;
    logic [STAT_W-1:0]  r_m_stat;
    logic               r_m_last;
    logic               out_free;
    t_result            result;
    t_mem_req           free_req;
    t_mem_req           recent_req;
    logic [FRAME_W-1:0] free_rdata;
    logic [FRAME_W-1:0] recent_rdata;

    // hold the region base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    rpfa_ram #(.DEPTH(NUM_FRAMES), .WIDTH(FRAME_W)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_req.we),
        .i_addr  (free_req.addr),
        .i_wdata (free_req.wdata),
        .o_rdata (free_rdata)
    );

    rpfa_ram #(.DEPTH(NUM_FRAMES), .WIDTH(FRAME_W)) u_recent_ram (
        .i_clk   (i_clk),
        .i_we    (recent_req.we),
        .i_addr  (recent_req.addr),
        .i_wdata (recent_req.wdata),
        .o_rdata (recent_rdata)
    );

    rpfa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_tvalid),
        .o_req_ready    (s_tready),
        .i_req_type     (s_tuser),
        .i_page_number  (s_tdata[19:0]),
        .i_random_value (s_tdata[51:20]),
        .i_dump_count   (s_tdata[58:52]),
        .i_base         (r_base),
        .i_out_free     (out_free),
        .o_result       (result),
        .o_free_req     (free_req),
        .i_free_rdata   (free_rdata),
        .o_recent_req   (recent_req),
        .i_recent_rdata (recent_rdata)
    );

    // output word register
    assign out_free = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_m_page <= result.page;
            r_m_stat <= result.status;
            r_m_last <= result.last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {4'b0, r_m_page};
    assign m_tuser  = r_m_stat;
    assign m_tlast  = r_m_last;

    // a new word never enters while the held one is stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !m_tready) |-> !result.valid)
        else $error("result pushed into a stalled output register");

    // an accepted allocate or free closes the input until it is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_ALLOC || s_tuser == REQ_FREE))
            |=> !s_tready)
        else $error("input reopened right after a request");

    // list writes never touch both RAMs in the same cycle
    a_single_ram_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(free_req.we && recent_req.we))
        else $error("both list RAMs written in one cycle");

endmodule
